FILE: hdl/tbclc_pkg.sv
package tbclc_pkg;

   localparam int HOLD_W = 16;
   localparam int MODE_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BUTTON = 1'b1;
   localparam logic BTN_START = 1'b0;
   localparam logic BTN_SETUP = 1'b1;

   localparam logic CSR_HOLD_TICKS = 1'b0;

   localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd3000;
   localparam logic [HOLD_W-1:0] HOLD_EXPIRED = 16'hFFFF;
   localparam logic [MODE_W-1:0] MODE_MAX = 4'd9;
   localparam logic [MODE_W-1:0] MODE_CAT_FIRST = 4'd5;

   localparam logic [7:0] BEEP_CLICK = 8'h01;
   localparam logic [7:0] BEEP_LEVEL = 8'h15;
   localparam logic [7:0] LOCK_PRESS = 8'h55;
   localparam logic [7:0] LOCK_ON = 8'hFF;
   localparam logic [7:0] LOCK_OFF = 8'h00;
   localparam logic [7:0] CAT_ON = 8'hFF;
   localparam logic [7:0] CAT_OFF = 8'h00;

   typedef struct packed {
      logic opcode;
      logic which_button;
      logic released;
      logic wash_running;
   } req_type;

   typedef struct packed {
      logic beep_valid;
      logic [7:0] beep_pattern;
      logic lock_led_valid;
      logic [7:0] lock_led_pattern;
      logic lock_led_repeat;
      logic mode_valid;
      logic [3:0] mode_leds;
      logic [7:0] cat_led_pattern;
      logic cat_led_repeat;
      logic start_wash;
      logic locked_now;
      logic [MODE_W-1:0] mode_now;
   } rsp_type;

   function automatic logic [3:0] mode_led_lookup(input logic [MODE_W-1:0] mode);
      logic [3:0] leds;
      case (mode)
         4'd1: leds = 4'h1;
         4'd2: leds = 4'h2;
         4'd3: leds = 4'h4;
         4'd4: leds = 4'h8;
         4'd5: leds = 4'h1;
         4'd6: leds = 4'h3;
         4'd7: leds = 4'h5;
         4'd8: leds = 4'h9;
         default: leds = 4'h0;
      endcase
      return leds;
   endfunction

endpackage

FILE: hdl/tbclc_csr.sv
module tbclc_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [tbclc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tbclc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tbclc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output logic [tbclc_pkg::HOLD_W-1:0] hold_ticks
);
   import tbclc_pkg::*;

   logic [HOLD_W-1:0] hold_ticks_ff;
   logic [HOLD_W-1:0] hold_ticks_in;
   logic reg_index;
   logic wr_en;

   // Registers sit on 4-byte boundaries; bit 2 selects the register.
   assign reg_index = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      hold_ticks_in = hold_ticks_ff;
      if (wr_en && reg_index == CSR_HOLD_TICKS) begin
         hold_ticks_in = csr_pwdata[HOLD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_TICKS_RESET;
      end else begin
         hold_ticks_ff <= hold_ticks_in;
      end
   end

   always_comb begin
      case (reg_index)
         CSR_HOLD_TICKS: csr_prdata = {{(CSR_DATA_W-HOLD_W){1'b0}}, hold_ticks_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign hold_ticks = hold_ticks_ff;

endmodule

FILE: hdl/tbclc_core.sv
module tbclc_core (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  tbclc_pkg::req_type item,
   input  logic [tbclc_pkg::HOLD_W-1:0] hold_ticks,
   output tbclc_pkg::rsp_type result,
   output logic produce
);
   import tbclc_pkg::*;

   logic start_held_ff, start_held_in;
   logic setup_held_ff, setup_held_in;
   logic chord_seen_ff, chord_seen_in;
   logic lock_flag_ff, lock_flag_in;
   logic [MODE_W-1:0] setup_mode_ff, setup_mode_in;
   logic [HOLD_W-1:0] hold_count_ff, hold_count_in;

   logic is_setup;
   logic other_held;
   logic [MODE_W-1:0] mode_step;

   assign is_setup = (item.which_button == BTN_SETUP);
   assign other_held = is_setup ? start_held_ff : setup_held_ff;
   // A stored mode above the top value also wraps to zero.
   assign mode_step = (setup_mode_ff >= MODE_MAX) ? '0 : setup_mode_ff + 1'b1;

   always_comb begin
      start_held_in = start_held_ff;
      setup_held_in = setup_held_ff;
      chord_seen_in = chord_seen_ff;
      lock_flag_in = lock_flag_ff;
      setup_mode_in = setup_mode_ff;
      hold_count_in = hold_count_ff;
      result = '0;
      produce = 1'b0;

      if (item.opcode == OP_TICK) begin
         if (hold_count_ff != HOLD_EXPIRED) begin
            hold_count_in = hold_count_ff + 1'b1;
         end
      end else begin
         produce = 1'b1;
         if (!item.released) begin
            if (is_setup) begin
               setup_held_in = 1'b1;
            end else begin
               start_held_in = 1'b1;
            end
            hold_count_in = '0;
            if (other_held) begin
               chord_seen_in = 1'b1;
            end
            if (!lock_flag_ff) begin
               result.beep_valid = 1'b1;
               result.beep_pattern = BEEP_CLICK;
            end else begin
               result.lock_led_valid = 1'b1;
               result.lock_led_pattern = LOCK_PRESS;
               result.lock_led_repeat = 1'b1;
            end
         end else begin
            if (is_setup) begin
               setup_held_in = 1'b0;
            end else begin
               start_held_in = 1'b0;
            end
            if (!chord_seen_ff) begin
               if (lock_flag_ff) begin
                  result.lock_led_valid = 1'b1;
                  result.lock_led_pattern = LOCK_ON;
                  result.lock_led_repeat = 1'b1;
               end else if (is_setup) begin
                  setup_mode_in = mode_step;
                  result.mode_valid = 1'b1;
                  result.mode_leds = mode_led_lookup(mode_step);
                  result.cat_led_pattern = (mode_step >= MODE_CAT_FIRST) ? CAT_ON : CAT_OFF;
                  result.cat_led_repeat = (mode_step >= MODE_CAT_FIRST);
               end else begin
                  result.start_wash = !item.wash_running;
               end
            end else if (!other_held) begin
               // Last button of a chord went up: decide on the lock.
               if (hold_count_ff >= hold_ticks) begin
                  lock_flag_in = !lock_flag_ff;
                  result.lock_led_valid = 1'b1;
                  result.lock_led_pattern = lock_flag_ff ? LOCK_OFF : LOCK_ON;
                  result.lock_led_repeat = !lock_flag_ff;
               end else if (lock_flag_ff) begin
                  result.lock_led_valid = 1'b1;
                  result.lock_led_pattern = LOCK_ON;
                  result.lock_led_repeat = 1'b1;
               end else begin
                  result.beep_valid = 1'b1;
                  result.beep_pattern = BEEP_LEVEL;
               end
               chord_seen_in = 1'b0;
            end
         end
      end
      result.locked_now = lock_flag_in;
      result.mode_now = setup_mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_held_ff <= 1'b0;
         setup_held_ff <= 1'b0;
         chord_seen_ff <= 1'b0;
         lock_flag_ff <= 1'b0;
         setup_mode_ff <= '0;
         hold_count_ff <= HOLD_EXPIRED;
      end else if (fire) begin
         start_held_ff <= start_held_in;
         setup_held_ff <= setup_held_in;
         chord_seen_ff <= chord_seen_in;
         lock_flag_ff <= lock_flag_in;
         setup_mode_ff <= setup_mode_in;
         hold_count_ff <= hold_count_in;
      end
   end

endmodule

FILE: hdl/two_button_chord_lock_controller_top.sv
// Chord lock controller for a start and a setup button. Each transaction on the req_ channel
// is a timer tick or a button event; every button event yields exactly one rsp_ transaction
// and ticks yield none. An item enters an input register, is evaluated combinationally against
// the button, chord, lock, mode and hold-counter state, and its result lands in an output
// register, so one item is accepted per clock while the input register does not stall, and
// each result is presented on the rsp_ port from the output register. The input register
// stalls only when a button event finds the output register full and stalled; ticks always pass.
// The hold time for a lock toggle is set through the csr_ port at byte address 0 (16 bits,
// reset 3000 ticks) and should be changed only while no items are in flight.
module two_button_chord_lock_controller_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  tbclc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tbclc_pkg::rsp_type rsp_data,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [tbclc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tbclc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tbclc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import tbclc_pkg::*;

   logic in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic [HOLD_W-1:0] hold_ticks;
   rsp_type core_result;
   logic core_produce;
   logic out_free;
   logic advance;
   logic req_accept;

   tbclc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .hold_ticks(hold_ticks)
   );

   tbclc_core u_core (
      .clock(clock),
      .reset(reset),
      .fire(advance),
      .item(in_data_ff),
      .hold_ticks(hold_ticks),
      .result(core_result),
      .produce(core_produce)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   // Ticks leave no result, so they never wait for the output register.
   assign advance = in_valid_ff && ((in_data_ff.opcode == OP_TICK) || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && core_produce) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance && core_produce) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && core_produce) |=> rsp_valid)
      else $error("evaluated button event did not reach the output register");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mode_now <= MODE_MAX))
      else $error("reported setup mode out of range");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.beep_valid) |-> !rsp_data.lock_led_valid)
      else $error("beep and lock LED command issued together");

endmodule

FILE: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbclc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int QUIET_CYCLES = 4;
   localparam logic BTN_DOWN = 1'b0;
   localparam logic BTN_UP = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] HOLD_TICKS_ADDR = {CSR_HOLD_TICKS, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   two_button_chord_lock_controller_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow of the controller state, advanced once per accepted transaction.
   logic [HOLD_W-1:0] hold_ticks = HOLD_TICKS_RESET;
   logic start_held = 1'b0;
   logic setup_held = 1'b0;
   logic chord_seen = 1'b0;
   logic lock_flag = 1'b0;
   logic [MODE_W-1:0] setup_mode = '0;
   logic [HOLD_W-1:0] hold_count = HOLD_EXPIRED;
   logic [3:0] leds_for_mode [10] = '{4'h0, 4'h1, 4'h2, 4'h4, 4'h8,
                                     4'h1, 4'h3, 4'h5, 4'h9, 4'h0};

   rsp_type expected_rsp_q[$];
   rsp_type want_rsp;
   bit idling_on = 1'b1;
   int stall_left = 0;
   int failures = 0;
   int items_sent = 0;
   int events_sent = 0;
   int results_checked = 0;
   int lock_toggles = 0;
   int cycle_count = 0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, expected_rsp_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic rsp_type with_lock_led(input rsp_type r, input logic [7:0] pattern,
                                             input logic rep);
      r.lock_led_valid = 1'b1;
      r.lock_led_pattern = pattern;
      r.lock_led_repeat = rep;
      return r;
   endfunction

   // Returns 1 when the transaction yields a result, which is placed in res.
   function automatic bit chord_lock_step(input req_type item, output rsp_type res);
      logic other;
      logic [MODE_W-1:0] next_mode;
      res = '0;
      if (item.opcode == OP_TICK) begin
         if (hold_count != HOLD_EXPIRED) hold_count++;
         return 1'b0;
      end
      other = (item.which_button == BTN_SETUP) ? start_held : setup_held;
      if (item.released == BTN_DOWN) begin
         if (item.which_button == BTN_SETUP) setup_held = 1'b1;
         else start_held = 1'b1;
         hold_count = '0;
         if (other) chord_seen = 1'b1;
         if (!lock_flag) begin
            res.beep_valid = 1'b1;
            res.beep_pattern = BEEP_CLICK;
         end else begin
            res = with_lock_led(res, LOCK_PRESS, 1'b1);
         end
      end else begin
         if (item.which_button == BTN_SETUP) setup_held = 1'b0;
         else start_held = 1'b0;
         if (!chord_seen) begin
            if (lock_flag) begin
               res = with_lock_led(res, LOCK_ON, 1'b1);
            end else if (item.which_button == BTN_SETUP) begin
               next_mode = (setup_mode >= MODE_MAX) ? '0 : setup_mode + 1'b1;
               setup_mode = next_mode;
               res.mode_valid = 1'b1;
               res.mode_leds = leds_for_mode[next_mode];
               res.cat_led_pattern = (next_mode >= MODE_CAT_FIRST) ? CAT_ON : CAT_OFF;
               res.cat_led_repeat = (next_mode >= MODE_CAT_FIRST);
            end else begin
               res.start_wash = !item.wash_running;
            end
         end else if (!other) begin
            if (hold_count >= hold_ticks) begin
               lock_flag = !lock_flag;
               lock_toggles++;
               res = lock_flag ? with_lock_led(res, LOCK_ON, 1'b1)
                               : with_lock_led(res, LOCK_OFF, 1'b0);
            end else if (lock_flag) begin
               res = with_lock_led(res, LOCK_ON, 1'b1);
            end else begin
               res.beep_valid = 1'b1;
               res.beep_pattern = BEEP_LEVEL;
            end
            chord_seen = 1'b0;
         end
      end
      res.locked_now = lock_flag;
      res.mode_now = setup_mode;
      return 1'b1;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         if (failures < 10)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field,
                     want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            if (failures < 10)
               $display("%0t: result 0x%0h arrived with nothing expected", $realtime,
                        rsp_data);
            failures++;
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            results_checked++;
            compare_field("beep_valid", 16'(rsp_data.beep_valid),
                          16'(want_rsp.beep_valid));
            compare_field("beep_pattern", 16'(rsp_data.beep_pattern),
                          16'(want_rsp.beep_pattern));
            compare_field("lock_led_valid", 16'(rsp_data.lock_led_valid),
                          16'(want_rsp.lock_led_valid));
            compare_field("lock_led_pattern", 16'(rsp_data.lock_led_pattern),
                          16'(want_rsp.lock_led_pattern));
            compare_field("lock_led_repeat", 16'(rsp_data.lock_led_repeat),
                          16'(want_rsp.lock_led_repeat));
            compare_field("mode_valid", 16'(rsp_data.mode_valid),
                          16'(want_rsp.mode_valid));
            compare_field("mode_leds", 16'(rsp_data.mode_leds),
                          16'(want_rsp.mode_leds));
            compare_field("cat_led_pattern", 16'(rsp_data.cat_led_pattern),
                          16'(want_rsp.cat_led_pattern));
            compare_field("cat_led_repeat", 16'(rsp_data.cat_led_repeat),
                          16'(want_rsp.cat_led_repeat));
            compare_field("start_wash", 16'(rsp_data.start_wash),
                          16'(want_rsp.start_wash));
            compare_field("locked_now", 16'(rsp_data.locked_now),
                          16'(want_rsp.locked_now));
            compare_field("mode_now", 16'(rsp_data.mode_now),
                          16'(want_rsp.mode_now));
         end
      end
   end

   // Result-side back pressure in bursts of random length.
   always @(negedge clock) begin
      if (reset || !idling_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type button_event(input logic button, input logic up,
                                            input logic wash);
      req_type item;
      item.opcode = OP_BUTTON;
      item.which_button = button;
      item.released = up;
      item.wash_running = wash;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      rsp_type res;
      gap = 0;
      if (idling_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (chord_lock_step(item, res)) begin
         expected_rsp_q.push_back(res);
         events_sent++;
      end
   endtask

   task automatic send_ticks(input int count);
      req_type item;
      repeat (count) begin
         item = '0;
         item.opcode = OP_TICK;
         item.which_button = 1'($urandom_range(0, 1));
         item.released = 1'($urandom_range(0, 1));
         item.wash_running = 1'($urandom_range(0, 1));
         send_item(item);
      end
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() > 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_hold_register();
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= HOLD_TICKS_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      compare_field("hold_ticks readback", got[15:0], hold_ticks);
   endtask

   task automatic set_hold_ticks(input logic [HOLD_W-1:0] value);
      wait_results_done();
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_write(HOLD_TICKS_ADDR, CSR_DATA_W'(value));
      hold_ticks = value;
      check_hold_register();
   endtask

   task automatic test_reset_value();
      check_hold_register();
   endtask

   // Lone presses and releases, a wash already running, presses of a held button,
   // a release of a button that is not held and a chord released too early.
   task automatic test_single_buttons();
      send_ticks(1);
      send_item(button_event(BTN_START, BTN_DOWN, 1'b1));
      send_item(button_event(BTN_START, BTN_UP, 1'b0));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_START, BTN_UP, 1'b1));
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b0));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b1));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b1));
      send_item(button_event(BTN_START, BTN_UP, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b0));
   endtask

   // With a one-tick hold: lock, actions while locked, a short chord while locked, unlock.
   task automatic test_chord_lock();
      set_hold_ticks(16'd1);
      send_item(button_event(BTN_START, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b0));
      send_ticks(1);
      send_item(button_event(BTN_START, BTN_UP, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b0));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b1));
      send_item(button_event(BTN_START, BTN_UP, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b0));
      send_item(button_event(BTN_START, BTN_UP, 1'b1));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b0));
      send_ticks(1);
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b0));
      send_item(button_event(BTN_START, BTN_UP, 1'b0));
   endtask

   // Mostly well-formed gestures: chords held around the hold time and lone clicks,
   // with some raw noise mixed in.
   task automatic test_random_gestures(input logic [HOLD_W-1:0] hold, input int n_items);
      int first_item;
      int cap;
      int pick;
      logic first;
      logic last;
      set_hold_ticks(hold);
      first_item = items_sent;
      cap = (hold > 60) ? 60 : int'(hold) + 3;
      while (items_sent - first_item < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            first = 1'($urandom_range(0, 1));
            send_item(button_event(first, BTN_DOWN, 1'($urandom_range(0, 1))));
            send_ticks($urandom_range(0, 2));
            send_item(button_event(!first, BTN_DOWN, 1'($urandom_range(0, 1))));
            send_ticks($urandom_range(0, cap));
            if ($urandom_range(0, 9) == 0)
               send_item(button_event(1'($urandom_range(0, 1)), BTN_DOWN,
                                      1'($urandom_range(0, 1))));
            last = 1'($urandom_range(0, 1));
            send_item(button_event(!last, BTN_UP, 1'($urandom_range(0, 1))));
            send_ticks($urandom_range(0, 1));
            send_item(button_event(last, BTN_UP, 1'($urandom_range(0, 1))));
         end else if (pick < 85) begin
            first = 1'($urandom_range(0, 1));
            send_item(button_event(first, BTN_DOWN, 1'($urandom_range(0, 1))));
            send_ticks($urandom_range(0, 3));
            send_item(button_event(first, BTN_UP, 1'($urandom_range(0, 1))));
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(req_type'(4'($urandom_range(0, 15))));
         end
         // Now and then the sender holds off until every result is back.
         if ($urandom_range(0, 39) == 0) wait_results_done();
      end
   endtask

   // Largest hold time: chords released long before the hold can expire.
   task automatic test_hold_extremes();
      set_hold_ticks(16'hFFFF);
      idling_on = 1'b0;
      send_item(button_event(BTN_START, BTN_DOWN, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b0));
      send_ticks(20);
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b0));
      send_item(button_event(BTN_START, BTN_UP, 1'b0));
      send_item(button_event(BTN_SETUP, BTN_DOWN, 1'b1));
      send_item(button_event(BTN_START, BTN_DOWN, 1'b1));
      send_ticks(30);
      send_item(button_event(BTN_START, BTN_UP, 1'b1));
      send_item(button_event(BTN_SETUP, BTN_UP, 1'b1));
      idling_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_reset_value();
      test_single_buttons();
      test_chord_lock();
      test_random_gestures(16'd1, 250);
      test_random_gestures(16'($urandom_range(2, 12)), 250);
      test_random_gestures(16'($urandom_range(13, 60)), 250);
      test_hold_extremes();
      idling_on = 1'b0;
      test_random_gestures(16'($urandom_range(1, 8)), 250);
      wait_results_done();
      repeat (QUIET_CYCLES) @(posedge clock);
      $display("Sent %0d transactions (%0d button events) and checked %0d results.",
               items_sent, events_sent, results_checked);
      $display("Hold times from 1 to 65535 ticks were used; the lock toggled %0d times.",
               lock_toggles);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
